// ===== hw/rtl/tilt_compensated_heading_macros.svh =====
// Assertion macros for the tilt compensated heading block.
// Needs a clock named clk and an active low reset named rst_n in scope.
`ifndef TILT_COMPENSATED_HEADING_MACROS_SVH
`define TILT_COMPENSATED_HEADING_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TCH_ASSERT_IMPLY(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
`define TCH_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define TCH_ASSERT_IMPLY(label, pre, post, msg)
`define TCH_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

// ===== hw/rtl/tch_pkg.sv =====
// Shared constants and the arctangent table for the tilt compensated heading block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tch_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ZW = 26;                  // angle accumulator, Q16 degrees
    localparam logic signed [ZW-1:0] Q16_DEG90 = 26'sd5898240;

    localparam logic [2:0] REG_BIAS_X   = 3'd0;
    localparam logic [2:0] REG_BIAS_Y   = 3'd1;
    localparam logic [2:0] REG_BIAS_Z   = 3'd2;
    localparam logic [2:0] REG_ROW_X    = 3'd3;
    localparam logic [2:0] REG_ROW_Y    = 3'd4;
    localparam logic [2:0] REG_ROW_Z    = 3'd5;
    localparam logic [2:0] REG_OFFSET   = 3'd6;

    // atan(2^-i) in Q16 degrees
    function automatic logic signed [ZW-1:0] atan_q16(input int i);
        logic signed [ZW-1:0] a;
        case (i)
            0:  a = 26'sd2949120;
            1:  a = 26'sd1740967;
            2:  a = 26'sd919879;
            3:  a = 26'sd466945;
            4:  a = 26'sd234379;
            5:  a = 26'sd117304;
            6:  a = 26'sd58666;
            7:  a = 26'sd29335;
            8:  a = 26'sd14668;
            9:  a = 26'sd7334;
            10: a = 26'sd3667;
            11: a = 26'sd1833;
            12: a = 26'sd917;
            13: a = 26'sd458;
            14: a = 26'sd229;
            15: a = 26'sd115;
            16: a = 26'sd57;
            17: a = 26'sd29;
            18: a = 26'sd14;
            19: a = 26'sd7;
            20: a = 26'sd4;
            21: a = 26'sd2;
            22: a = 26'sd1;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/tilt_compensated_heading.sv =====
// One sample per cycle, except while a stall holds the pipeline.
// The pipeline holds a 16-stage square root and three CORDIC pipelines,
// one stage per iteration. A stall freezes every stage at once.
// Reset clears valid bits and loads the calibration registers; data regs hold.
// Top level: tilt compensated compass heading, pitch and roll.
// Depends on tch_pkg, tch_cordic_vec and tilt_compensated_heading_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "tilt_compensated_heading_macros.svh"
module tilt_compensated_heading
    import tch_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [47:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    input  logic signed [15:0] mag_x,
    input  logic signed [15:0] mag_y,
    input  logic signed [15:0] mag_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [14:0]        heading_angle,
    output logic signed [13:0] pitch_angle,
    output logic signed [14:0] roll_angle
);

    localparam int S      = CORDIC_STEPS;
    localparam int LAT    = 27 + 3 * S;
    localparam int ISQ    = 16;
    localparam int MW     = 29;
    localparam int CW     = 18;
    localparam int RW     = 33;
    localparam int HW     = 49;
    localparam int M_DLY  = 20 + 2 * S;
    localparam int A_DLY  = 6 + 2 * S;
    localparam logic signed [RW-1:0] KINV = 33'sd652032874;

    // configuration
    logic signed [20:0] bias_reg [0:2];
    logic [47:0]        row_reg  [0:2];
    logic [14:0]        offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_reg[0] <= -21'sd13888;
            bias_reg[1] <= 21'sd41;
            bias_reg[2] <= -21'sd10989;
            row_reg[0]  <= 48'd281337530236895;
            row_reg[1]  <= 48'd277395837943824;
            row_reg[2]  <= 48'd70085318278955;
            offset_reg  <= 15'd6400;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BIAS_X: bias_reg[0] <= cfg_data[20:0];
                REG_BIAS_Y: bias_reg[1] <= cfg_data[20:0];
                REG_BIAS_Z: bias_reg[2] <= cfg_data[20:0];
                REG_ROW_X:  row_reg[0]  <= cfg_data;
                REG_ROW_Y:  row_reg[1]  <= cfg_data;
                REG_ROW_Z:  row_reg[2]  <= cfg_data;
                REG_OFFSET: offset_reg  <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // pipeline control: every stage advances together
    logic en;
    logic vld_reg [1:LAT];

    assign en        = !(vld_reg[LAT] && out_stall);
    assign in_stall  = !en;
    assign out_valid = vld_reg[LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= LAT; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[1] <= in_valid;
            for (int k = 2; k <= LAT; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    // stage 1: bias removal and the y and z accelerometer squares
    logic signed [15:0] mag_in [0:2];
    logic signed [24:0] mb_reg [0:2];
    logic signed [15:0] ax1_reg, ay1_reg, az1_reg;
    logic [31:0]        sqy_reg, sqz_reg;

    assign mag_in[0] = mag_x;
    assign mag_in[1] = mag_y;
    assign mag_in[2] = mag_z;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
                mb_reg[c] <= {mag_in[c][15], mag_in[c], 8'd0}
                             - {{4{bias_reg[c][20]}}, bias_reg[c]};
            ax1_reg <= accel_x;
            ay1_reg <= accel_y;
            az1_reg <= accel_z;
            sqy_reg <= 32'(accel_y * accel_y);
            sqz_reg <= 32'(accel_z * accel_z);
        end
    end

    // stage 2: calibration products and sum of squares
    logic signed [40:0] prod_reg [0:2][0:2];
    logic [32:0]        sumsq_reg;
    logic signed [15:0] ax2_reg, ay2_reg, az2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    prod_reg[r][c] <= $signed(row_reg[r][16*c +: 16]) * mb_reg[c];
            sumsq_reg <= {1'b0, sqy_reg} + {1'b0, sqz_reg};
            ax2_reg   <= ax1_reg;
            ay2_reg   <= ay1_reg;
            az2_reg   <= az1_reg;
        end
    end

    // stage 3: calibrated field, Q8
    logic signed [MW-1:0] m_reg [0:2];
    logic signed [42:0]   msum  [0:2];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            msum[r] = 43'(prod_reg[r][0]) + 43'(prod_reg[r][1]) + 43'(prod_reg[r][2]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
                m_reg[r] <= MW'(msum[r] >>> 14);
        end
    end

    // integer square root, one result bit per stage
    logic [32:0] rem_reg [0:ISQ-1];
    logic [32:0] res_reg [0:ISQ-1];

    genvar k;
    generate
        for (k = 0; k < ISQ; k++)
        begin : g_isqrt
            localparam logic [32:0] BIT = 33'd1 << (30 - 2 * k);
            logic [32:0] rem_in, res_in, trial;
            if (k == 0)
            begin : g_first
                assign rem_in = sumsq_reg;
                assign res_in = '0;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[k-1];
                assign res_in = res_reg[k-1];
            end
            assign trial = res_in + BIT;
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (rem_in >= trial)
                    begin
                        rem_reg[k] <= rem_in - trial;
                        res_reg[k] <= (res_in >> 1) + BIT;
                    end
                    else
                    begin
                        rem_reg[k] <= rem_in;
                        res_reg[k] <= res_in >> 1;
                    end
                end
            end
        end
    endgenerate

    // accelerometer travels alongside the root
    logic [47:0] acc_dly_reg [0:ISQ-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc_dly_reg[0] <= {ax2_reg, ay2_reg, az2_reg};
            for (int j = 1; j < ISQ; j++)
                acc_dly_reg[j] <= acc_dly_reg[j-1];
        end
    end

    logic signed [15:0] ax_d, ay_d, az_d;
    assign ax_d = acc_dly_reg[ISQ-1][47:32];
    assign ay_d = acc_dly_reg[ISQ-1][31:16];
    assign az_d = acc_dly_reg[ISQ-1][15:0];

    // pitch and roll angles
    logic signed [27:0]   pv_x, pv_y, rv_x, rv_y;
    logic signed [ZW-1:0] pitch_z, roll_z;

    assign pv_x = {12'd0, res_reg[ISQ-1][15:0]};
    assign pv_y = -{{12{ax_d[15]}}, ax_d};
    assign rv_x = {{12{az_d[15]}}, az_d};
    assign rv_y = {{12{ay_d[15]}}, ay_d};

    tch_cordic_vec #(.W(28), .STEPS(S)) u_pitch_vec
    (
        .clk   (clk),
        .en    (en),
        .x_in  (pv_x),
        .y_in  (pv_y),
        .z_out (pitch_z)
    );

    tch_cordic_vec #(.W(28), .STEPS(S)) u_roll_vec
    (
        .clk   (clk),
        .en    (en),
        .x_in  (rv_x),
        .y_in  (rv_y),
        .z_out (roll_z)
    );

    function automatic logic signed [16:0] round_sat(input logic signed [ZW-1:0] z,
                                                     input logic signed [16:0] lim);
        logic signed [ZW:0] t;
        logic signed [16:0] a;
        t = (ZW+1)'(z) + (ZW+1)'(512);
        a = 17'(t >>> 10);
        if (a > lim)
            a = lim;
        if (a < -lim)
            a = -lim;
        return a;
    endfunction

    logic signed [13:0] pitch_reg;
    logic signed [14:0] roll_reg;
    logic signed [16:0] pitch_r, roll_r;

    assign pitch_r = round_sat(pitch_z, 17'sd5760);
    assign roll_r  = round_sat(roll_z, 17'sd11520);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pitch_reg <= pitch_r[13:0];
            roll_reg  <= roll_r[14:0];
        end
    end

    // sine and cosine of pitch (lane 0) and roll (lane 1)
    logic signed [RW-1:0] rx_reg [0:1][0:S];
    logic signed [RW-1:0] ry_reg [0:1][0:S];
    logic signed [ZW-1:0] rz_reg [0:1][0:S];
    logic signed [ZW-1:0] ang_q16 [0:1];

    assign ang_q16[0] = {{2{pitch_reg[13]}}, pitch_reg, 10'd0};
    assign ang_q16[1] = {roll_reg[14], roll_reg, 10'd0};

    genvar l, i;
    generate
        for (l = 0; l < 2; l++)
        begin : g_lane
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (ang_q16[l] > Q16_DEG90)
                    begin
                        rx_reg[l][0] <= '0;
                        ry_reg[l][0] <= KINV;
                        rz_reg[l][0] <= ang_q16[l] - Q16_DEG90;
                    end
                    else if (ang_q16[l] < -Q16_DEG90)
                    begin
                        rx_reg[l][0] <= '0;
                        ry_reg[l][0] <= -KINV;
                        rz_reg[l][0] <= ang_q16[l] + Q16_DEG90;
                    end
                    else
                    begin
                        rx_reg[l][0] <= KINV;
                        ry_reg[l][0] <= '0;
                        rz_reg[l][0] <= ang_q16[l];
                    end
                end
            end
            for (i = 0; i < S; i++)
            begin : g_rot
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        if (rz_reg[l][i] >= 0)
                        begin
                            rx_reg[l][i+1] <= rx_reg[l][i] - (ry_reg[l][i] >>> i);
                            ry_reg[l][i+1] <= ry_reg[l][i] + (rx_reg[l][i] >>> i);
                            rz_reg[l][i+1] <= rz_reg[l][i] - atan_q16(i);
                        end
                        else
                        begin
                            rx_reg[l][i+1] <= rx_reg[l][i] + (ry_reg[l][i] >>> i);
                            ry_reg[l][i+1] <= ry_reg[l][i] - (rx_reg[l][i] >>> i);
                            rz_reg[l][i+1] <= rz_reg[l][i] + atan_q16(i);
                        end
                    end
                end
            end
        end
    endgenerate

    // round Q30 to Q15
    logic signed [CW-1:0] cp_reg, sp_reg, cr_reg, sr_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cp_reg <= CW'((rx_reg[0][S] + RW'(16384)) >>> 15);
            sp_reg <= CW'((ry_reg[0][S] + RW'(16384)) >>> 15);
            cr_reg <= CW'((rx_reg[1][S] + RW'(16384)) >>> 15);
            sr_reg <= CW'((ry_reg[1][S] + RW'(16384)) >>> 15);
        end
    end

    // cross terms of roll and pitch
    logic signed [CW-1:0] srsp_reg, crsp_reg, cp2_reg, cr2_reg, sr2_reg;
    logic signed [2*CW-1:0] srsp_p, crsp_p;

    assign srsp_p = sr_reg * sp_reg;
    assign crsp_p = cr_reg * sp_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            srsp_reg <= CW'((srsp_p + (2*CW)'(16384)) >>> 15);
            crsp_reg <= CW'((crsp_p + (2*CW)'(16384)) >>> 15);
            cp2_reg  <= cp_reg;
            cr2_reg  <= cr_reg;
            sr2_reg  <= sr_reg;
        end
    end

    // calibrated field delayed to meet the trig terms
    logic [3*MW-1:0] m_dly_reg [0:M_DLY-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_dly_reg[0] <= {m_reg[0], m_reg[1], m_reg[2]};
            for (int j = 1; j < M_DLY; j++)
                m_dly_reg[j] <= m_dly_reg[j-1];
        end
    end

    logic signed [MW-1:0] mx_d, my_d, mz_d;
    assign mx_d = m_dly_reg[M_DLY-1][3*MW-1:2*MW];
    assign my_d = m_dly_reg[M_DLY-1][2*MW-1:MW];
    assign mz_d = m_dly_reg[M_DLY-1][MW-1:0];

    // tilt compensation products, then sums
    logic signed [MW+CW-1:0] p_xc_reg, p_ysp_reg, p_zcp_reg, p_ycr_reg, p_zsr_reg;
    logic signed [HW-1:0]    xh_reg, yh_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_xc_reg  <= mx_d * cp2_reg;
            p_ysp_reg <= my_d * srsp_reg;
            p_zcp_reg <= mz_d * crsp_reg;
            p_ycr_reg <= my_d * cr2_reg;
            p_zsr_reg <= mz_d * sr2_reg;
            xh_reg    <= HW'(p_xc_reg) + HW'(p_ysp_reg) - HW'(p_zcp_reg);
            yh_reg    <= HW'(p_ycr_reg) + HW'(p_zsr_reg);
        end
    end

    // heading angle
    logic signed [ZW-1:0]   head_z;
    logic signed [HW+9:0]   hv_x, hv_y;

    assign hv_x = (HW+10)'(xh_reg);
    assign hv_y = (HW+10)'(yh_reg);

    tch_cordic_vec #(.W(HW+10), .STEPS(S)) u_head_vec
    (
        .clk   (clk),
        .en    (en),
        .x_in  (hv_x),
        .y_in  (hv_y),
        .z_out (head_z)
    );

    // pitch and roll wait for the heading
    logic [28:0] ang_dly_reg [0:A_DLY-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ang_dly_reg[0] <= {pitch_reg, roll_reg};
            for (int j = 1; j < A_DLY; j++)
                ang_dly_reg[j] <= ang_dly_reg[j-1];
        end
    end

    // add offset and wrap once into a full turn
    logic signed [16:0] head_r;
    logic signed [17:0] hsum, hwrap;

    assign head_r = round_sat(head_z, 17'sd11520);

    always_comb
    begin
        hsum  = 18'(head_r) + $signed({3'd0, offset_reg});
        hwrap = hsum;
        if (hsum < 0)
            hwrap = hsum + 18'sd23040;
        else if (hsum >= 18'sd23040)
            hwrap = hsum - 18'sd23040;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            heading_angle <= hwrap[14:0];
            pitch_angle   <= ang_dly_reg[A_DLY-1][28:15];
            roll_angle    <= ang_dly_reg[A_DLY-1][14:0];
        end
    end

    `TCH_ASSERT_IMPLY(a_heading_range, out_valid, heading_angle < 15'd23040,
        "heading outside a full turn")
    `TCH_ASSERT_IMPLY(a_pitch_range, out_valid,
        (pitch_angle <= 14'sd5760) && (pitch_angle >= -14'sd5760),
        "pitch beyond saturation limit")
    `TCH_ASSERT_IMPLY(a_roll_range, out_valid,
        (roll_angle <= 15'sd11520) && (roll_angle >= -15'sd11520),
        "roll beyond saturation limit")
    `TCH_ASSERT_NEXT(a_drain, out_valid && !out_stall && !vld_reg[LAT-1], !out_valid,
        "result repeated after transfer")

endmodule
`default_nettype wire

// ===== hw/rtl/tch_cordic_vec.sv =====
// Pipelined CORDIC in vectoring mode: angle of (x, y) in Q16 degrees.
// Depends on tch_pkg for the arctangent table.
`timescale 1ns / 1ps
`default_nettype none
module tch_cordic_vec
    import tch_pkg::*;
#(
    parameter int W     = 28,
    parameter int STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [W-1:0]  x_in,
    input  logic signed [W-1:0]  y_in,
    output logic signed [ZW-1:0] z_out
);

    logic signed [W-1:0]  x_reg    [0:STEPS];
    logic signed [W-1:0]  y_reg    [0:STEPS];
    logic signed [ZW-1:0] z_reg    [0:STEPS];
    logic                 zero_reg [0:STEPS];

    logic signed [W-1:0]  xs, ys, x_next, y_next;
    logic signed [ZW-1:0] z_next;

    // scale up and fold the left half plane over by a quarter turn
    always_comb
    begin
        xs = x_in <<< 8;
        ys = y_in <<< 8;
        x_next = xs;
        y_next = ys;
        z_next = '0;
        if (xs < 0)
        begin
            if (ys >= 0)
            begin
                x_next = ys;
                y_next = -xs;
                z_next = Q16_DEG90;
            end
            else
            begin
                x_next = -ys;
                y_next = xs;
                z_next = -Q16_DEG90;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= x_next;
            y_reg[0]    <= y_next;
            z_reg[0]    <= z_next;
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
        end
    end

    genvar i;
    generate
        for (i = 0; i < STEPS; i++)
        begin : g_step
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    zero_reg[i+1] <= zero_reg[i];
                    if (y_reg[i] > 0)
                    begin
                        x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                        y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                        z_reg[i+1] <= z_reg[i] + atan_q16(i);
                    end
                    else
                    begin
                        x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                        y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                        z_reg[i+1] <= z_reg[i] - atan_q16(i);
                    end
                end
            end
        end
    endgenerate

    assign z_out = zero_reg[STEPS] ? '0 : z_reg[STEPS];

endmodule
`default_nettype wire
